>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define MFPR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define MFPR_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define MFPR_ASSERT(name, prop, msg)
`define MFPR_ASSERT_NEVER(name, expr, msg)

`endif

`endif

>>> hw/rtl/mfpr_pkg.sv
// Types and constants of the magic-framed packet receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mfpr_pkg;

    localparam int MAX_MAGIC_BYTES = 4;
    localparam int NUM_TYPES       = 4;
    localparam int LEN_BITS        = 8;
    localparam int WIN_IDX_W       = $clog2(MAX_MAGIC_BYTES);
    localparam int CNT_W           = 3;
    localparam int TYPE_W          = 2;
    localparam int MAGIC_W         = 32;
    localparam int TICKS_W         = 16;
    localparam int TOTAL_W         = 32;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;
    localparam int ENTRY_W         = 40;

    localparam logic [CNT_W-1:0]   MAGIC_RESET   = 3'd1;
    localparam logic [CNT_W-1:0]   TYPES_RESET   = 3'd1;
    localparam logic [TICKS_W-1:0] TICKS_RESET   = 16'd1000;

    typedef enum logic [2:0] {
        REG_MAGIC_BYTES   = 3'd0,
        REG_TYPES_IN_USE  = 3'd1,
        REG_ENTRY_A       = 3'd2,
        REG_ENTRY_B       = 3'd3,
        REG_ENTRY_C       = 3'd4,
        REG_ENTRY_D       = 3'd5,
        REG_FAILSAFE      = 3'd6,
        REG_REACQUIRE     = 3'd7
    } reg_idx_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_kind_t;

    // Effective configuration, ranges already clamped
    typedef struct packed {
        logic [CNT_W-1:0]                      magic_len;
        logic [CNT_W-1:0]                      types;
        logic [NUM_TYPES-1:0][MAGIC_W-1:0]     magic;
        logic [NUM_TYPES-1:0][LEN_BITS-1:0]    len;
        logic [TICKS_W-1:0]                    failsafe_ticks;
        logic [TICKS_W-1:0]                    reacquire_ticks;
    } mfpr_cfg_t;

    // Events from the deframer to the link supervisor
    typedef struct packed {
        logic                tick;
        logic                done;
        logic                dropped;
        logic [LEN_BITS-1:0] len;
    } mfpr_evt_t;

    // Per-request result fields of the deframer
    typedef struct packed {
        logic              pv;
        logic [7:0]        pb;
        logic [TYPE_W-1:0] pt;
        logic              last;
        logic              dropped;
    } mfpr_res_t;

endpackage

>>> hw/rtl/mfpr_cfg.sv
// APB register file of the magic-framed packet receiver.
// Depends on mfpr_pkg; drives the clamped configuration struct.
`timescale 1ns / 1ps

module mfpr_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfpr_pkg::ADDR_W-1:0] paddr,
    input  logic [mfpr_pkg::DATA_W-1:0] pwdata,
    output logic [mfpr_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mfpr_pkg::mfpr_cfg_t         cfg,
    output logic                        win_clear
);
    import mfpr_pkg::*;

    logic [CNT_W-1:0]                   magic_bytes_reg;
    logic [CNT_W-1:0]                   types_reg;
    logic [NUM_TYPES-1:0][ENTRY_W-1:0]  entry_reg;
    logic [TICKS_W-1:0]                 failsafe_reg;
    logic [TICKS_W-1:0]                 reacquire_reg;
    logic                               wr_en;
    reg_idx_t                           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

    // Hold the register values written over the bus
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_bytes_reg <= MAGIC_RESET;
            types_reg       <= TYPES_RESET;
            entry_reg       <= '0;
            failsafe_reg    <= TICKS_RESET;
            reacquire_reg   <= TICKS_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MAGIC_BYTES:  magic_bytes_reg <= pwdata[CNT_W-1:0];
                REG_TYPES_IN_USE: types_reg       <= pwdata[CNT_W-1:0];
                REG_ENTRY_A:      entry_reg[0]    <= pwdata[ENTRY_W-1:0];
                REG_ENTRY_B:      entry_reg[1]    <= pwdata[ENTRY_W-1:0];
                REG_ENTRY_C:      entry_reg[2]    <= pwdata[ENTRY_W-1:0];
                REG_ENTRY_D:      entry_reg[3]    <= pwdata[ENTRY_W-1:0];
                REG_FAILSAFE:     failsafe_reg    <= pwdata[TICKS_W-1:0];
                REG_REACQUIRE:    reacquire_reg   <= pwdata[TICKS_W-1:0];
                default:          ;
            endcase
        end
    end

    // A new magic length empties the hunt window
    assign win_clear = wr_en && (idx == REG_MAGIC_BYTES);

    // Return the stored value of the addressed register
    always_comb
    begin
        case (idx)
            REG_MAGIC_BYTES:  prdata = DATA_W'(magic_bytes_reg);
            REG_TYPES_IN_USE: prdata = DATA_W'(types_reg);
            REG_ENTRY_A:      prdata = DATA_W'(entry_reg[0]);
            REG_ENTRY_B:      prdata = DATA_W'(entry_reg[1]);
            REG_ENTRY_C:      prdata = DATA_W'(entry_reg[2]);
            REG_ENTRY_D:      prdata = DATA_W'(entry_reg[3]);
            REG_FAILSAFE:     prdata = DATA_W'(failsafe_reg);
            REG_REACQUIRE:    prdata = DATA_W'(reacquire_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp lengths and counts into their working ranges
    always_comb
    begin
        if (magic_bytes_reg == '0)
            cfg.magic_len = CNT_W'(1);
        else if (magic_bytes_reg > CNT_W'(MAX_MAGIC_BYTES))
            cfg.magic_len = CNT_W'(MAX_MAGIC_BYTES);
        else
            cfg.magic_len = magic_bytes_reg;

        if (types_reg == '0)
            cfg.types = CNT_W'(1);
        else if (types_reg > CNT_W'(NUM_TYPES))
            cfg.types = CNT_W'(NUM_TYPES);
        else
            cfg.types = types_reg;

        for (int k = 0; k < NUM_TYPES; k++)
        begin
            cfg.magic[k] = entry_reg[k][MAGIC_W-1:0];
            cfg.len[k]   = entry_reg[k][MAGIC_W +: LEN_BITS];
        end

        cfg.failsafe_ticks  = (failsafe_reg == '0) ? TICKS_W'(1) : failsafe_reg;
        cfg.reacquire_ticks = (reacquire_reg == '0) ? TICKS_W'(1) : reacquire_reg;
    end

endmodule

>>> hw/rtl/mfpr_deframer.sv
// Magic hunt window, entry compare and payload tracking.
// Depends on mfpr_pkg; feeds events to mfpr_supervisor.
`timescale 1ns / 1ps

module mfpr_deframer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                req_type,
    input  logic [7:0]          rx_byte,
    input  mfpr_pkg::mfpr_cfg_t cfg,
    input  logic                win_clear,
    output mfpr_pkg::mfpr_res_t res,
    output mfpr_pkg::mfpr_evt_t evt
);
    import mfpr_pkg::*;

    logic [MAX_MAGIC_BYTES-1:0][7:0] win_reg, win_next, win_app, win_shift;
    logic [CNT_W-1:0]                fill_reg, fill_next, fill_base, fill_inc;
    logic                            in_payload_reg, in_payload_next;
    logic [TYPE_W-1:0]               cur_type_reg, cur_type_next;
    logic [LEN_BITS-1:0]             bytes_left_reg, bytes_left_next;
    logic [NUM_TYPES-1:0]            hit_vec;
    logic                            hit, full;
    logic [TYPE_W-1:0]               hit_type;

    // Append the byte to the window and prepare the shifted copy
    always_comb
    begin
        fill_base = (fill_reg >= CNT_W'(MAX_MAGIC_BYTES)) ? '0 : fill_reg;
        win_app = win_reg;
        win_app[fill_base[WIN_IDX_W-1:0]] = rx_byte;
        fill_inc = fill_base + 1'b1;
        full = (fill_inc >= cfg.magic_len);
        for (int i = 0; i < MAX_MAGIC_BYTES - 1; i++)
            win_shift[i] = win_app[i+1];
        win_shift[MAX_MAGIC_BYTES-1] = win_app[MAX_MAGIC_BYTES-1];
    end

    // Compare the window with every active entry, lowest index wins
    always_comb
    begin
        for (int k = 0; k < NUM_TYPES; k++)
        begin
            hit_vec[k] = (CNT_W'(k) < cfg.types);
            for (int i = 0; i < MAX_MAGIC_BYTES; i++)
                if ((CNT_W'(i) < cfg.magic_len) && (win_app[i] != cfg.magic[k][8*i +: 8]))
                    hit_vec[k] = 1'b0;
        end
        hit = 1'b0;
        hit_type = '0;
        for (int k = NUM_TYPES - 1; k >= 0; k--)
            if (hit_vec[k])
            begin
                hit = 1'b1;
                hit_type = TYPE_W'(k);
            end
    end

    // Decide the outcome of the request held in the input stage
    always_comb
    begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        cur_type_next   = cur_type_reg;
        bytes_left_next = bytes_left_reg;
        res             = '0;
        evt             = '0;

        if (req_type == REQ_TICK)
        begin
            evt.tick = 1'b1;
        end
        else if (in_payload_reg)
        begin
            res.pv = 1'b1;
            res.pb = rx_byte;
            res.pt = cur_type_reg;
            bytes_left_next = bytes_left_reg - 1'b1;
            if (bytes_left_next == '0)
            begin
                in_payload_next = 1'b0;
                res.last = 1'b1;
                evt.done = 1'b1;
                evt.len  = cfg.len[cur_type_reg];
            end
        end
        else
        begin
            win_next  = win_app;
            fill_next = fill_inc;
            if (full)
            begin
                if (hit)
                begin
                    fill_next     = '0;
                    cur_type_next = hit_type;
                    res.pt        = hit_type;
                    if (cfg.len[hit_type] == '0)
                    begin
                        res.last = 1'b1;
                        evt.done = 1'b1;
                    end
                    else
                    begin
                        in_payload_next = 1'b1;
                        bytes_left_next = cfg.len[hit_type];
                    end
                end
                else
                begin
                    // Drop the oldest byte and keep hunting
                    win_next    = win_shift;
                    fill_next   = cfg.magic_len - 1'b1;
                    res.dropped = 1'b1;
                    evt.dropped = 1'b1;
                end
            end
        end
    end

    // Advance the framing state with each request that moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg        <= '0;
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            cur_type_reg   <= '0;
            bytes_left_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                win_reg        <= win_next;
                in_payload_reg <= in_payload_next;
                cur_type_reg   <= cur_type_next;
                bytes_left_reg <= bytes_left_next;
            end
            // A new magic length empties the window ahead of any request
            if (win_clear)
                fill_reg <= '0;
            else if (advance)
                fill_reg <= fill_next;
        end
    end

endmodule

>>> hw/rtl/mfpr_supervisor.sv
// Failsafe and reacquire timers, link flag and statistics counters.
// Depends on mfpr_pkg; driven by events from mfpr_deframer.
`timescale 1ns / 1ps

module mfpr_supervisor
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  mfpr_pkg::mfpr_evt_t          evt,
    input  mfpr_pkg::mfpr_cfg_t          cfg,
    output logic                         link_up,
    output logic [mfpr_pkg::TOTAL_W-1:0] failsafe_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] reacquire_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] error_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] packet_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] good_byte_total
);
    import mfpr_pkg::*;

    logic [TICKS_W-1:0] fs_left_reg, fs_left_next, rq_left_reg, rq_left_next;
    logic               fs_run_reg, fs_run_next, rq_run_reg, rq_run_next;
    logic               link_reg, link_next;
    logic [TOTAL_W-1:0] fs_cnt_reg, fs_cnt_next, rq_cnt_reg, rq_cnt_next;
    logic [TOTAL_W-1:0] err_cnt_reg, err_cnt_next, pkt_cnt_reg, pkt_cnt_next;
    logic [TOTAL_W-1:0] good_cnt_reg, good_cnt_next;

    // Counters and link flag always show the state after the last request
    assign link_up         = link_reg;
    assign failsafe_total  = fs_cnt_reg;
    assign reacquire_total = rq_cnt_reg;
    assign error_total     = err_cnt_reg;
    assign packet_total    = pkt_cnt_reg;
    assign good_byte_total = good_cnt_reg;

    always_comb
    begin
        fs_left_next  = fs_left_reg;
        fs_run_next   = fs_run_reg;
        rq_left_next  = rq_left_reg;
        rq_run_next   = rq_run_reg;
        link_next     = link_reg;
        fs_cnt_next   = fs_cnt_reg;
        rq_cnt_next   = rq_cnt_reg;
        err_cnt_next  = err_cnt_reg;
        pkt_cnt_next  = pkt_cnt_reg;
        good_cnt_next = good_cnt_reg;

        if (evt.tick)
        begin
            // Failsafe first, so a joint expiry leaves the link valid
            if (fs_run_reg)
            begin
                fs_left_next = fs_left_reg - 1'b1;
                if (fs_left_next == '0)
                begin
                    fs_run_next = 1'b0;
                    link_next   = 1'b0;
                    fs_cnt_next = fs_cnt_reg + 1'b1;
                end
            end
            if (rq_run_reg)
            begin
                rq_left_next = rq_left_reg - 1'b1;
                if (rq_left_next == '0)
                begin
                    rq_run_next = 1'b0;
                    link_next   = 1'b1;
                    rq_cnt_next = rq_cnt_reg + 1'b1;
                end
            end
        end
        else if (evt.dropped)
        begin
            err_cnt_next = err_cnt_reg + 1'b1;
            rq_run_next  = 1'b0;
            rq_left_next = '0;
        end
        else if (evt.done)
        begin
            pkt_cnt_next  = pkt_cnt_reg + 1'b1;
            good_cnt_next = good_cnt_reg + TOTAL_W'(cfg.magic_len)
                          + TOTAL_W'(evt.len);
            fs_left_next  = cfg.failsafe_ticks;
            fs_run_next   = 1'b1;
            if (!link_reg && !rq_run_reg)
            begin
                rq_left_next = cfg.reacquire_ticks;
                rq_run_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_left_reg  <= '0;
            fs_run_reg   <= 1'b0;
            rq_left_reg  <= '0;
            rq_run_reg   <= 1'b0;
            link_reg     <= 1'b0;
            fs_cnt_reg   <= '0;
            rq_cnt_reg   <= '0;
            err_cnt_reg  <= '0;
            pkt_cnt_reg  <= '0;
            good_cnt_reg <= '0;
        end
        else if (advance)
        begin
            fs_left_reg  <= fs_left_next;
            fs_run_reg   <= fs_run_next;
            rq_left_reg  <= rq_left_next;
            rq_run_reg   <= rq_run_next;
            link_reg     <= link_next;
            fs_cnt_reg   <= fs_cnt_next;
            rq_cnt_reg   <= rq_cnt_next;
            err_cnt_reg  <= err_cnt_next;
            pkt_cnt_reg  <= pkt_cnt_next;
            good_cnt_reg <= good_cnt_next;
        end
    end

endmodule

>>> hw/rtl/magic_framed_packet_receiver.sv
// Top level of the magic-framed packet receiver: input stage, result stage.
// Depends on mfpr_pkg, mfpr_cfg, mfpr_deframer, mfpr_supervisor, assert_macros.svh.
//
// Usage:
//   Request channel (req_valid / req_stall): req_type 0 carries rx_byte,
//   req_type 1 is one timer tick. Result channel (res_valid / res_stall):
//   one result per request, in order, with payload fields, drop flag,
//   link flag and the five wrapping statistics counters after that request.
//   Path: a request accepted into the input register has its result loaded
//   into the result register once the result stage is free, raising
//   res_valid. Throughput is one request per cycle while res_stall is low;
//   the hunt compare, payload count and timer update all settle within the
//   single stage between the input register and the result register.
//   Stall: while a result waits under res_stall, one further request is
//   taken into the input stage; req_stall then rises until the result moves.
//   Reset: rst_n clears framing, timers, link flag and counters and loads
//   the register defaults (magic length 1, one entry, 1000-tick timers).
//   Registers sit on an APB port at byte address 8 * index; writes are
//   meant for idle periods only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module magic_framed_packet_receiver
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         req_type,
    input  logic [7:0]                   rx_byte,
    // Result channel
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         payload_valid,
    output logic [7:0]                   payload_byte,
    output logic [mfpr_pkg::TYPE_W-1:0]  packet_type,
    output logic                         payload_last,
    output logic                         byte_dropped,
    output logic                         link_up,
    output logic [mfpr_pkg::TOTAL_W-1:0] failsafe_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] reacquire_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] error_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] packet_total,
    output logic [mfpr_pkg::TOTAL_W-1:0] good_byte_total,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfpr_pkg::ADDR_W-1:0]  paddr,
    input  logic [mfpr_pkg::DATA_W-1:0]  pwdata,
    output logic [mfpr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import mfpr_pkg::*;

    logic               s1_valid_reg;
    logic               s1_type_reg;
    logic [7:0]         s1_byte_reg;
    logic               res_valid_reg;
    mfpr_res_t          res_reg;
    mfpr_res_t          res_next;
    mfpr_evt_t          evt;
    mfpr_cfg_t          cfg;
    logic               win_clear;
    logic               accept;
    logic               advance;
    logic               adv_drop;
    logic               adv_tick;
    logic               res_drop_bad;
    logic [TOTAL_W-1:0] err_inc;

    // Move the held request on whenever the result stage is free or draining
    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    // Input stage: hold one request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg <= req_type;
            s1_byte_reg <= rx_byte;
        end
    end

    mfpr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .win_clear (win_clear)
    );

    mfpr_deframer u_deframer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_type  (s1_type_reg),
        .rx_byte   (s1_byte_reg),
        .cfg       (cfg),
        .win_clear (win_clear),
        .res       (res_next),
        .evt       (evt)
    );

    mfpr_supervisor u_supervisor
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .evt             (evt),
        .cfg             (cfg),
        .link_up         (link_up),
        .failsafe_total  (failsafe_total),
        .reacquire_total (reacquire_total),
        .error_total     (error_total),
        .packet_total    (packet_total),
        .good_byte_total (good_byte_total)
    );

    // Result stage: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign res_valid     = res_valid_reg;
    assign payload_valid = res_reg.pv;
    assign payload_byte  = res_reg.pb;
    assign packet_type   = res_reg.pt;
    assign payload_last  = res_reg.last;
    assign byte_dropped  = res_reg.dropped;

    // Checks
    assign adv_drop     = advance && evt.dropped;
    assign adv_tick     = advance && (s1_type_reg == REQ_TICK);
    assign res_drop_bad = res_reg.dropped && (res_reg.pv || res_reg.last);
    assign err_inc      = error_total + 32'd1;

    `MFPR_ASSERT(a_adv_fills_result, advance |=> res_valid_reg, "advanced request lost")
    `MFPR_ASSERT(a_err_step, adv_drop |=> (error_total == $past(err_inc)), "drop not counted")
    `MFPR_ASSERT(a_link_rise_on_tick, $rose(link_up) |-> $past(adv_tick), "link raised off tick")
    `MFPR_ASSERT_NEVER(a_drop_excl, res_valid_reg && res_drop_bad, "drop together with payload")

endmodule
